[rtl/mbvc_pkg.sv]
// ----------------------------------------------------------------------------
// Metaball voxel classifier package
// Shared sizes, command and status codes, register indexes and the types
// that pass between the classifier's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mbvc_pkg;

	localparam int MAX_BALLS = 16;
	localparam int MAX_GRID  = 32;
	localparam int PSTRIDE   = MAX_GRID + 1;
	localparam int NPOINTS   = PSTRIDE * PSTRIDE * PSTRIDE;
	localparam int NVOXELS   = MAX_GRID * MAX_GRID * MAX_GRID;

	localparam int PADDR_W  = $clog2(NPOINTS);
	localparam int VADDR_W  = $clog2(NVOXELS);
	localparam int SLOT_W   = 4;
	localparam int COORD_W  = 16;
	localparam int MASS_W   = 16;
	localparam int ENERGY_W = 32;
	localparam int GRID_W   = 6;
	localparam int VIDX_W   = 5;
	localparam int VSIZE_W  = 15;
	localparam int NBALL_W  = 5;
	localparam int CFG_W    = 32;
	localparam int CFGIDX_W = 2;

	localparam int DIST2_MIN = 26844;
	localparam int ONE_Q14   = 16384;
	localparam int QUOT_W    = 30;

	localparam logic [1:0] CMD_LOAD     = 2'd0;
	localparam logic [1:0] CMD_CLEAR    = 2'd1;
	localparam logic [1:0] CMD_CLASSIFY = 2'd2;
	localparam logic [1:0] CMD_UNUSED   = 2'd3;

	localparam logic [1:0] ST_CLASSIFIED = 2'd0;
	localparam logic [1:0] ST_LOADED     = 2'd1;
	localparam logic [1:0] ST_CLEARED    = 2'd2;
	localparam logic [1:0] ST_RANGE      = 2'd3;

	localparam logic [CFGIDX_W-1:0] REG_LEVEL  = 2'd0;
	localparam logic [CFGIDX_W-1:0] REG_GRID   = 2'd1;
	localparam logic [CFGIDX_W-1:0] REG_VSIZE  = 2'd2;
	localparam logic [CFGIDX_W-1:0] REG_ACTIVE = 2'd3;

	typedef struct packed {
		logic                      we;
		logic [SLOT_W-1:0]         slot;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic [MASS_W-1:0]         mass;
	} ball_load_t;

	typedef struct packed {
		logic               start;
		logic [GRID_W-1:0]  gx;
		logic [GRID_W-1:0]  gy;
		logic [GRID_W-1:0]  gz;
		logic [VSIZE_W-1:0] vsize;
		logic [NBALL_W-1:0] nballs;
	} field_req_t;

	// Corner offsets as {z, y, x}.
	function automatic logic [2:0] corner_off(input logic [2:0] k);
		logic [2:0] r;
		unique case (k)
			3'd0: r = 3'b000;
			3'd1: r = 3'b001;
			3'd2: r = 3'b101;
			3'd3: r = 3'b100;
			3'd4: r = 3'b010;
			3'd5: r = 3'b011;
			3'd6: r = 3'b111;
			3'd7: r = 3'b110;
			default: r = 3'b000;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/mbvc_mark_store.sv]
// ----------------------------------------------------------------------------
// Metaball classifier mark store
// Grid point memory holding a done mark and the cached energy, and a voxel
// memory holding the voxel done mark. One write and one read port each.
// ----------------------------------------------------------------------------
`default_nettype none

module mbvc_mark_store (
	input  wire logic                         clk,
	input  wire logic                         pt_rd,
	input  wire logic [mbvc_pkg::PADDR_W-1:0] pt_raddr,
	output logic [mbvc_pkg::ENERGY_W:0]       pt_rdata,
	input  wire logic                         pt_we,
	input  wire logic [mbvc_pkg::PADDR_W-1:0] pt_waddr,
	input  wire logic [mbvc_pkg::ENERGY_W:0]  pt_wdata,
	input  wire logic                         vx_rd,
	input  wire logic [mbvc_pkg::VADDR_W-1:0] vx_raddr,
	output logic                              vx_rdata,
	input  wire logic                         vx_we,
	input  wire logic [mbvc_pkg::VADDR_W-1:0] vx_waddr,
	input  wire logic                         vx_wdata
);
	import mbvc_pkg::*;

	logic [ENERGY_W:0] pt_mem [NPOINTS];
	logic              vx_mem [NVOXELS];

	always_ff @(posedge clk) begin
		if (pt_we) begin
			pt_mem[pt_waddr] <= pt_wdata;
		end
		if (pt_rd) begin
			pt_rdata <= pt_mem[pt_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (vx_we) begin
			vx_mem[vx_waddr] <= vx_wdata;
		end
		if (vx_rd) begin
			vx_rdata <= vx_mem[vx_raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/mbvc_field_unit.sv]
// ----------------------------------------------------------------------------
// Metaball classifier field unit
// Holds the ball table and sums mass / max(d^2, min) over the active balls
// for one grid point, one ball at a time through a radix-2 divider.
// ----------------------------------------------------------------------------
`default_nettype none

module mbvc_field_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire mbvc_pkg::ball_load_t          load,
	input  wire mbvc_pkg::field_req_t          req,
	output logic                               fdone,
	output logic [mbvc_pkg::ENERGY_W-1:0]      energy
);
	import mbvc_pkg::*;

	typedef enum logic [5:0] {
		F_IDLE = 6'b000001,
		F_POS  = 6'b000010,
		F_SQ   = 6'b000100,
		F_SUM  = 6'b001000,
		F_DIV  = 6'b010000,
		F_ACC  = 6'b100000
	} fstate_t;

	localparam int P_W   = 22;
	localparam int ABS_W = 21;
	localparam int SQ_W  = 2 * ABS_W;
	localparam int D2_W  = SQ_W + 2;

	fstate_t state_q;

	logic signed [COORD_W-1:0] bx_q [MAX_BALLS];
	logic signed [COORD_W-1:0] by_q [MAX_BALLS];
	logic signed [COORD_W-1:0] bz_q [MAX_BALLS];
	logic [MASS_W-1:0]         bm_q [MAX_BALLS];

	logic [GRID_W-1:0]   gx_q, gy_q, gz_q;
	logic [VSIZE_W-1:0]  vs_q;
	logic [NBALL_W-1:0]  n_q, i_q;
	logic signed [P_W-1:0] px_q, py_q, pz_q;
	logic [SQ_W-1:0]     sqx_q, sqy_q, sqz_q;
	logic [D2_W-1:0]     d2_q;
	logic [D2_W-1:0]     rem_q;
	logic [QUOT_W-1:0]   num_q;
	logic [4:0]          cnt_q;
	logic [ENERGY_W-1:0] acc_q;

	logic [SLOT_W-1:0]     bi;
	logic signed [P_W-1:0] dx, dy, dz;
	logic [ABS_W-1:0]      ax, ay, az;
	logic [D2_W-1:0]       d2_sum;
	logic [D2_W:0]         rem_sh;
	logic                  ge;
	logic [ENERGY_W:0]     acc_sum;
	logic [ENERGY_W-1:0]   acc_sat;
	logic [NBALL_W-1:0]    n_use;

	function automatic logic signed [P_W-1:0] world(input logic [GRID_W-1:0] g,
		input logic [VSIZE_W-1:0] vs);
		logic [GRID_W+VSIZE_W-1:0] prod;
		prod = g * vs;
		return $signed({1'b0, prod}) - P_W'(ONE_Q14);
	endfunction

	function automatic logic [ABS_W-1:0] mag(input logic signed [P_W-1:0] d);
		logic signed [P_W-1:0] n;
		n = -d;
		return d[P_W-1] ? n[ABS_W-1:0] : d[ABS_W-1:0];
	endfunction

	assign bi = i_q[SLOT_W-1:0];
	assign dx = P_W'(bx_q[bi]) - px_q;
	assign dy = P_W'(by_q[bi]) - py_q;
	assign dz = P_W'(bz_q[bi]) - pz_q;
	assign ax = mag(dx);
	assign ay = mag(dy);
	assign az = mag(dz);
	assign d2_sum = D2_W'(sqx_q) + D2_W'(sqy_q) + D2_W'(sqz_q);
	assign rem_sh = {rem_q, num_q[QUOT_W-1]};
	assign ge = rem_sh >= {1'b0, d2_q};
	assign acc_sum = {1'b0, acc_q} + (ENERGY_W+1)'(num_q);
	assign acc_sat = acc_sum[ENERGY_W] ? '1 : acc_sum[ENERGY_W-1:0];
	assign n_use = (req.nballs > NBALL_W'(MAX_BALLS)) ? NBALL_W'(MAX_BALLS) : req.nballs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < MAX_BALLS; b++) begin
				bx_q[b] <= '0;
				by_q[b] <= '0;
				bz_q[b] <= '0;
				bm_q[b] <= MASS_W'(256);
			end
		end else if (load.we) begin
			bx_q[load.slot] <= load.x;
			by_q[load.slot] <= load.y;
			bz_q[load.slot] <= load.z;
			bm_q[load.slot] <= load.mass;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			fdone   <= 1'b0;
			i_q     <= '0;
			n_q     <= '0;
			cnt_q   <= '0;
		end else begin
			fdone <= 1'b0;
			unique case (state_q)
				F_IDLE: begin
					if (req.start) begin
						gx_q    <= req.gx;
						gy_q    <= req.gy;
						gz_q    <= req.gz;
						vs_q    <= req.vsize;
						n_q     <= n_use;
						i_q     <= '0;
						acc_q   <= '0;
						state_q <= F_POS;
					end
				end
				F_POS: begin
					px_q <= world(gx_q, vs_q);
					py_q <= world(gy_q, vs_q);
					pz_q <= world(gz_q, vs_q);
					if (n_q == '0) begin
						energy  <= '0;
						fdone   <= 1'b1;
						state_q <= F_IDLE;
					end else begin
						state_q <= F_SQ;
					end
				end
				F_SQ: begin
					sqx_q   <= ax * ax;
					sqy_q   <= ay * ay;
					sqz_q   <= az * az;
					state_q <= F_SUM;
				end
				F_SUM: begin
					d2_q    <= (d2_sum < D2_W'(DIST2_MIN)) ? D2_W'(DIST2_MIN) : d2_sum;
					rem_q   <= D2_W'(bm_q[bi][MASS_W-1:2]);
					num_q   <= {bm_q[bi][1:0], (QUOT_W-2)'(0)};
					cnt_q   <= 5'(QUOT_W);
					state_q <= F_DIV;
				end
				F_DIV: begin
					rem_q <= ge ? D2_W'(rem_sh - {1'b0, d2_q}) : rem_sh[D2_W-1:0];
					num_q <= {num_q[QUOT_W-2:0], ge};
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd1) begin
						state_q <= F_ACC;
					end
				end
				F_ACC: begin
					acc_q <= acc_sat;
					i_q   <= i_q + NBALL_W'(1);
					if (i_q + NBALL_W'(1) == n_q) begin
						energy  <= acc_sat;
						fdone   <= 1'b1;
						state_q <= F_IDLE;
					end else begin
						state_q <= F_SQ;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/metaball_voxel_classifier_unit.sv]
// ----------------------------------------------------------------------------
// Metaball voxel classifier
// Classifies voxels of a metaball field into marching cubes case indexes,
// caching grid point energies and voxel marks in memories until a clear.
// ----------------------------------------------------------------------------
// Load, unused and out of range commands give their result 1 cycle after
// acceptance. A classify with all corners cached reads and compares the eight
// corners in turn; an uncached inner corner adds a field evaluation with one
// radix-2 division (30 quotient bits) per active ball. A clear sweeps the
// point memory, and after reset the same sweep runs with busy high and no
// result. A new beat is taken when busy is low. The receiver cannot stall.
`default_nettype none

module metaball_voxel_classifier_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [1:0]                          cmd,
	input  wire logic [mbvc_pkg::SLOT_W-1:0]         ball_slot,
	input  wire logic signed [mbvc_pkg::COORD_W-1:0] ball_x,
	input  wire logic signed [mbvc_pkg::COORD_W-1:0] ball_y,
	input  wire logic signed [mbvc_pkg::COORD_W-1:0] ball_z,
	input  wire logic [mbvc_pkg::MASS_W-1:0]         ball_mass,
	input  wire logic [mbvc_pkg::VIDX_W-1:0]         voxel_x,
	input  wire logic [mbvc_pkg::VIDX_W-1:0]         voxel_y,
	input  wire logic [mbvc_pkg::VIDX_W-1:0]         voxel_z,
	output logic                                     done,
	output logic [7:0]                               case_index,
	output logic                                     voxel_was_done,
	output logic [1:0]                               status,
	input  wire logic                                cfg_we,
	input  wire logic [mbvc_pkg::CFGIDX_W-1:0]       cfg_index,
	input  wire logic [mbvc_pkg::CFG_W-1:0]          cfg_data
);
	import mbvc_pkg::*;

	typedef enum logic [8:0] {
		T_IDLE  = 9'b000000001,
		T_CLEAR = 9'b000000010,
		T_PRD   = 9'b000000100,
		T_PCHK  = 9'b000001000,
		T_FIELD = 9'b000010000,
		T_PWR   = 9'b000100000,
		T_CMP   = 9'b001000000,
		T_VRD   = 9'b010000000,
		T_VCHK  = 9'b100000000
	} tstate_t;

	tstate_t state_q;

	logic [ENERGY_W-1:0] level_q;
	logic [GRID_W-1:0]   grid_q;
	logic [VSIZE_W-1:0]  vsize_q;
	logic [NBALL_W-1:0]  active_q;

	logic [PADDR_W-1:0]  clr_q;
	logic                clr_report_q;
	logic [VIDX_W-1:0]   vx_q, vy_q, vz_q;
	logic [GRID_W-1:0]   g_q;
	logic [2:0]          k_q;
	logic [7:0]          case_q;
	logic [GRID_W-1:0]   cx_q, cy_q, cz_q;
	logic [PADDR_W-1:0]  paddr_q;
	logic [ENERGY_W-1:0] e_q;

	logic [GRID_W-1:0]   g_use;
	logic                accept;
	logic                out_of_range;
	logic [2:0]          off;
	logic [GRID_W-1:0]   cx, cy, cz;
	logic [PADDR_W-1:0]  paddr;
	logic [VADDR_W-1:0]  vaddr;
	logic                border;

	ball_load_t          load;
	field_req_t          req;
	logic                fdone;
	logic [ENERGY_W-1:0] fenergy;

	logic                pt_rd, pt_we, vx_rd, vx_we, vx_wdata;
	logic [PADDR_W-1:0]  pt_waddr;
	logic [ENERGY_W:0]   pt_rdata, pt_wdata;
	logic [VADDR_W-1:0]  vx_waddr;
	logic                vx_rdata;

	assign g_use = (grid_q < GRID_W'(2)) ? GRID_W'(2) :
		(grid_q > GRID_W'(MAX_GRID)) ? GRID_W'(MAX_GRID) : grid_q;
	assign accept = start && !busy;
	assign busy = (state_q != T_IDLE);
	assign out_of_range = ({1'b0, voxel_x} >= g_use) || ({1'b0, voxel_y} >= g_use) ||
		({1'b0, voxel_z} >= g_use);

	assign off = corner_off(k_q);
	assign cx = GRID_W'(vx_q) + GRID_W'(off[0]);
	assign cy = GRID_W'(vy_q) + GRID_W'(off[1]);
	assign cz = GRID_W'(vz_q) + GRID_W'(off[2]);
	assign paddr = PADDR_W'(cx) + PADDR_W'(cy) * PADDR_W'(PSTRIDE) +
		PADDR_W'(cz) * PADDR_W'(PSTRIDE * PSTRIDE);
	assign vaddr = VADDR_W'(vx_q) + VADDR_W'(vy_q) * VADDR_W'(MAX_GRID) +
		VADDR_W'(vz_q) * VADDR_W'(MAX_GRID * MAX_GRID);
	assign border = (cx_q == '0) || (cy_q == '0) || (cz_q == '0) ||
		(cx_q == g_q) || (cy_q == g_q) || (cz_q == g_q);

	always_comb begin
		load.we   = accept && (cmd == CMD_LOAD);
		load.slot = ball_slot;
		load.x    = ball_x;
		load.y    = ball_y;
		load.z    = ball_z;
		load.mass = ball_mass;

		req.start  = (state_q == T_PCHK) && !pt_rdata[ENERGY_W] && !border;
		req.gx     = cx_q;
		req.gy     = cy_q;
		req.gz     = cz_q;
		req.vsize  = vsize_q;
		req.nballs = active_q;
	end

	always_comb begin
		pt_rd    = (state_q == T_PRD);
		pt_we    = (state_q == T_CLEAR) || (state_q == T_PWR);
		pt_waddr = (state_q == T_CLEAR) ? clr_q : paddr_q;
		pt_wdata = (state_q == T_CLEAR) ? '0 : {1'b1, e_q};
		vx_rd    = (state_q == T_VRD);
		vx_we    = ((state_q == T_CLEAR) && (clr_q < PADDR_W'(NVOXELS))) ||
			(state_q == T_VCHK);
		vx_waddr = (state_q == T_CLEAR) ? clr_q[VADDR_W-1:0] : vaddr;
		vx_wdata = (state_q == T_VCHK);
	end

	mbvc_field_unit u_field (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.req    (req),
		.fdone  (fdone),
		.energy (fenergy)
	);

	mbvc_mark_store u_store (
		.clk      (clk),
		.pt_rd    (pt_rd),
		.pt_raddr (paddr),
		.pt_rdata (pt_rdata),
		.pt_we    (pt_we),
		.pt_waddr (pt_waddr),
		.pt_wdata (pt_wdata),
		.vx_rd    (vx_rd),
		.vx_raddr (vaddr),
		.vx_rdata (vx_rdata),
		.vx_we    (vx_we),
		.vx_waddr (vx_waddr),
		.vx_wdata (vx_wdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= ENERGY_W'(25600);
			grid_q   <= GRID_W'(16);
			vsize_q  <= VSIZE_W'(2048);
			active_q <= NBALL_W'(8);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LEVEL:  level_q  <= cfg_data[ENERGY_W-1:0];
				REG_GRID:   grid_q   <= cfg_data[GRID_W-1:0];
				REG_VSIZE:  vsize_q  <= cfg_data[VSIZE_W-1:0];
				REG_ACTIVE: active_q <= cfg_data[NBALL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= T_CLEAR;
			clr_q        <= '0;
			clr_report_q <= 1'b0;
			k_q          <= '0;
			done         <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				T_IDLE: begin
					if (accept) begin
						unique case (cmd)
							CMD_LOAD: begin
								done           <= 1'b1;
								status         <= ST_LOADED;
								case_index     <= '0;
								voxel_was_done <= 1'b0;
							end
							CMD_CLEAR: begin
								clr_q        <= '0;
								clr_report_q <= 1'b1;
								state_q      <= T_CLEAR;
							end
							CMD_CLASSIFY: begin
								if (out_of_range) begin
									done           <= 1'b1;
									status         <= ST_RANGE;
									case_index     <= '0;
									voxel_was_done <= 1'b0;
								end else begin
									vx_q    <= voxel_x;
									vy_q    <= voxel_y;
									vz_q    <= voxel_z;
									g_q     <= g_use;
									k_q     <= '0;
									case_q  <= '0;
									state_q <= T_PRD;
								end
							end
							CMD_UNUSED: begin
								done           <= 1'b1;
								status         <= ST_RANGE;
								case_index     <= '0;
								voxel_was_done <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				T_CLEAR: begin
					clr_q <= clr_q + PADDR_W'(1);
					if (clr_q == PADDR_W'(NPOINTS - 1)) begin
						state_q <= T_IDLE;
						if (clr_report_q) begin
							done           <= 1'b1;
							status         <= ST_CLEARED;
							case_index     <= '0;
							voxel_was_done <= 1'b0;
						end
						clr_report_q <= 1'b0;
					end
				end
				T_PRD: begin
					cx_q    <= cx;
					cy_q    <= cy;
					cz_q    <= cz;
					paddr_q <= paddr;
					state_q <= T_PCHK;
				end
				T_PCHK: begin
					if (pt_rdata[ENERGY_W]) begin
						e_q     <= pt_rdata[ENERGY_W-1:0];
						state_q <= T_CMP;
					end else if (border) begin
						e_q     <= '0;
						state_q <= T_PWR;
					end else begin
						state_q <= T_FIELD;
					end
				end
				T_FIELD: begin
					if (fdone) begin
						e_q     <= fenergy;
						state_q <= T_PWR;
					end
				end
				T_PWR: begin
					state_q <= T_CMP;
				end
				T_CMP: begin
					case_q[k_q] <= (e_q > level_q);
					k_q         <= k_q + 3'd1;
					state_q     <= (k_q == 3'd7) ? T_VRD : T_PRD;
				end
				T_VRD: begin
					state_q <= T_VCHK;
				end
				T_VCHK: begin
					done           <= 1'b1;
					status         <= ST_CLASSIFIED;
					case_index     <= case_q;
					voxel_was_done <= vx_rdata;
					state_q        <= T_IDLE;
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while a command is still in progress");

	a_load_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd == CMD_LOAD)) |=> (done && (status == ST_LOADED)))
		else $error("ball load did not report in the next cycle");

	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_CLASSIFIED)) |-> ((case_index == '0) && !voxel_was_done))
		else $error("non-classify result carries corner or voxel bits");

	a_field_only_inner: assert property (@(posedge clk) disable iff (!arst_n)
		fdone |-> (state_q == T_FIELD))
		else $error("field unit finished outside a field evaluation");

endmodule

`default_nettype wire
